>>> rtl/core/sdr_pkg.sv
// sdr_pkg: shared widths for the stable duplicate removal block
// no dependencies; used by the top level
package sdr_pkg;

	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [COUNT_W-1:0] count_t;

endpackage

>>> rtl/core/stable_duplicate_removal_top.sv
// stable_duplicate_removal_top: first-occurrence filter over a stream of array elements
// depends on sdr_pkg and sdr_cell
//
// Usage:
//   Input channel (valid, stall, value, last_in) carries one array element per
//   transfer; last_in marks the final element of an array. Output channel
//   (res_valid, res_stall, value_out, keep, last_out, unique_count, overflow)
//   returns exactly one result per input transfer, in order.
//   The result of a transfer is on the output registers in the cycle after it.
//   One element per cycle is taken while results drain; the
//   store is a chain of MAX_ITEMS cells that all compare the new element in the
//   same cycle, and a new value shifts into the head of the chain.
//   keep is 1 for a first occurrence. When the chain is full a new value is kept
//   with overflow set and not stored. After the last element the fill count goes
//   back to zero, ready for the next array.
//   While res_stall holds a waiting result, stall is raised and no element is
//   taken. Reset empties the store (fill count zero) and drops any held result;
//   no clearing pass is needed.
module stable_duplicate_removal_top #(
	parameter int MAX_ITEMS  = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	output logic                    stall,
	input  sdr_pkg::value_t         value,
	input  logic                    last_in,
	output logic                    res_valid,
	input  logic                    res_stall,
	output sdr_pkg::value_t         value_out,
	output logic                    keep,
	output logic                    last_out,
	output sdr_pkg::count_t         unique_count,
	output logic                    overflow
);

	import sdr_pkg::*;

	localparam int CW   = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
	localparam int CNTW = $clog2(MAX_ITEMS + 1);

	logic [CNTW-1:0]  count_q;
	logic [CNTW-1:0]  count_after;
	logic [CW-1:0]    probe;
	logic [CW-1:0]    chain [MAX_ITEMS+1];
	logic [MAX_ITEMS-1:0] hits;
	logic             acc;
	logic             hit;
	logic             full;
	logic             ins;
	logic [CNTW+COUNT_W-1:0] count_wide;

	logic             res_valid_q;
	value_t           value_out_q;
	logic             keep_q;
	logic             last_out_q;
	count_t           unique_count_q;
	logic             overflow_q;

	assign stall = res_valid_q && res_stall;
	assign acc   = valid && !stall;
	assign probe = value[CW-1:0];

	assign chain[0] = probe;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		sdr_cell #(
			.W     (CW),
			.CNTW  (CNTW),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.shift_en (ins),
			.data_in  (chain[i]),
			.probe    (probe),
			.count    (count_q),
			.data_out (chain[i+1]),
			.hit      (hits[i])
		);
	end

	assign hit         = |hits;
	assign full        = (count_q == CNTW'(MAX_ITEMS));
	assign ins         = acc && !hit && !full;
	assign count_after = ins ? count_q + CNTW'(1) : count_q;
	assign count_wide  = {{COUNT_W{1'b0}}, count_after};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= last_in ? '0 : count_after;
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			value_out_q    <= VALUE_W'(probe);
			keep_q         <= !hit;
			last_out_q     <= last_in;
			unique_count_q <= count_wide[COUNT_W-1:0];
			overflow_q     <= !hit && full;
		end
	end

	assign res_valid    = res_valid_q;
	assign value_out    = value_out_q;
	assign keep         = keep_q;
	assign last_out     = last_out_q;
	assign unique_count = unique_count_q;
	assign overflow     = overflow_q;

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last_in |=> count_q == '0)
		else $error("fill count not cleared after last element");

	a_repeat_holds: assert property (@(posedge clk) disable iff (!arst_n)
		acc && hit && !last_in |=> count_q == $past(count_q))
		else $error("repeat changed the fill count");

	a_overflow_kept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && overflow_q |-> keep_q)
		else $error("overflow on a dropped element");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_ITEMS))
		else $error("fill count beyond store depth");

endmodule

>>> rtl/core/sdr_cell.sv
// sdr_cell: one store cell of the seen-value chain
// holds one value, takes its neighbor's value on a shift, compares against the probe
module sdr_cell #(
	parameter int W     = 32,
	parameter int CNTW  = 7,
	parameter int INDEX = 0
) (
	input  logic            clk,
	input  logic            shift_en,
	input  logic [W-1:0]    data_in,
	input  logic [W-1:0]    probe,
	input  logic [CNTW-1:0] count,
	output logic [W-1:0]    data_out,
	output logic            hit
);

	logic [W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			data_q <= data_in;
		end
	end

	// entry is live only below the fill count
	assign hit      = (CNTW'(INDEX) < count) && (data_q == probe);
	assign data_out = data_q;

endmodule

>>> sim/tb_stable_duplicate_removal_top.sv
// tb_stable_duplicate_removal_top: self-checking bench for the first-occurrence filter
// depends on sdr_pkg and stable_duplicate_removal_top; the expected results come
// from a model of the seen-value store kept inside this file
module tb_stable_duplicate_removal_top;
	import sdr_pkg::*;

	localparam int STORE_DEPTH = 64;
	localparam int IDLE_LIMIT  = 2000;

	typedef struct {
		value_t v;
		logic   keep;
		logic   last;
		count_t cnt;
		logic   ovf;
	} dedup_res_t;

	logic   clk;
	logic   arst_n    = 1'b0;
	logic   valid     = 1'b0;
	logic   stall;
	value_t value     = '0;
	logic   last_in   = 1'b0;
	logic   res_valid;
	logic   res_stall = 1'b0;
	value_t value_out;
	logic   keep;
	logic   last_out;
	count_t unique_count;
	logic   overflow;

	value_t     seen_tab [STORE_DEPTH];
	int         seen_n       = 0;
	dedup_res_t pending_res[$];
	int         mismatch_cnt = 0;
	bit         quiet        = 1'b0;
	int         hold_ask     = 0;

	stable_duplicate_removal_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid        (valid),
		.stall        (stall),
		.value        (value),
		.last_in      (last_in),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.value_out    (value_out),
		.keep         (keep),
		.last_out     (last_out),
		.unique_count (unique_count),
		.overflow     (overflow)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic dedup_res_t dedup_predict(value_t v, logic lst);
		dedup_res_t r;
		logic       hit;
		int         i;
		hit = 1'b0;
		for (i = 0; i < seen_n; i++)
			if (seen_tab[i] == v)
				hit = 1'b1;
		r.v    = v;
		r.last = lst;
		r.keep = !hit;
		r.ovf  = 1'b0;
		if (!hit) begin
			if (seen_n < STORE_DEPTH) begin
				seen_tab[seen_n] = v;
				seen_n++;
			end else begin
				r.ovf = 1'b1;
			end
		end
		r.cnt = count_t'(seen_n);
		if (lst)
			seen_n = 0;
		return r;
	endfunction

	function automatic void note_error(string msg);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%s", msg);
	endfunction

	function automatic void cmp_field(string fname, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			note_error($sformatf("%s mismatch: expected %h, got %h", fname, want, got));
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one element per call; valid stays high when the next transfer follows at once
	task automatic send_elem(value_t v, logic lst);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		valid   <= 1'b1;
		value   <= v;
		last_in <= lst;
		do @(posedge clk); while (stall !== 1'b0);
		pending_res.push_back(dedup_predict(v, lst));
	endtask

	// receiver side: random stalls, or a long hold when one is requested
	initial begin : res_side
		int   run;
		logic st;
		run = 0;
		st  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask > 0) begin
				run      = hold_ask;
				hold_ask = 0;
				st       = 1'b1;
			end else if (run <= 0) begin
				if (quiet) begin
					st  = 1'b0;
					run = 1;
				end else begin
					st  = ($urandom_range(0, 3) == 0);
					run = st ? pick_gap() + 1 : $urandom_range(1, 8);
				end
			end
			res_stall <= st;
			run--;
		end
	end

	initial begin : result_check
		dedup_res_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0) begin
				if (pending_res.size() == 0) begin
					note_error($sformatf("unexpected result: value_out %h", value_out));
				end else begin
					want = pending_res.pop_front();
					cmp_field("value_out", value_out, want.v);
					cmp_field("keep", 32'(keep), 32'(want.keep));
					cmp_field("last_out", 32'(last_out), 32'(want.last));
					cmp_field("unique_count", 32'(unique_count), 32'(want.cnt));
					cmp_field("overflow", 32'(overflow), 32'(want.ovf));
				end
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((valid === 1'b1 && stall === 1'b0) || (res_valid === 1'b1 && res_stall === 1'b0))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("tb_stable_duplicate_removal_top: errors");
				$finish;
			end
		end
	end

	task automatic test_corner_values();
		send_elem(32'h0000_0000, 1'b0);
		send_elem(32'hFFFF_FFFF, 1'b0);
		send_elem(32'h0000_0000, 1'b0);
		send_elem(32'h8000_0000, 1'b0);
		send_elem(32'h0000_0001, 1'b0);
		send_elem(32'hFFFF_FFFF, 1'b0);
		send_elem(32'h5555_5555, 1'b0);
		send_elem(32'hAAAA_AAAA, 1'b0);
		// repeat on the closing element still ends the array
		send_elem(32'h5555_5555, 1'b1);
		send_elem(32'h0000_0000, 1'b1);
		send_elem(32'hAAAA_AAAA, 1'b0);
		send_elem(32'hAAAA_AAAA, 1'b0);
		send_elem(32'hAAAA_AAAA, 1'b1);
		send_elem(32'h7FFF_FFFF, 1'b0);
		send_elem(32'hFFFF_FFFE, 1'b1);
	endtask

	// fills the store exactly; the first round ends the array there, the later rounds then push past it
	task automatic test_full_store();
		value_t hi;
		int     rnd;
		int     i;
		int     extra;
		for (rnd = 0; rnd < 3; rnd++) begin
			hi = $urandom;
			for (i = 0; i < STORE_DEPTH; i++)
				send_elem({hi[31:7], 7'(i)}, (rnd == 0) && (i == STORE_DEPTH - 1));
			if (rnd != 0) begin
				extra = $urandom_range(4, 12);
				for (i = 0; i < extra; i++) begin
					case ($urandom_range(0, 3))
						0: send_elem({hi[31:7], 7'($urandom_range(0, STORE_DEPTH - 1))}, 1'b0);
						1: send_elem({hi[31:7], 7'($urandom_range(64, 127))}, 1'b0);
						2: send_elem({hi[31:7], 7'd64}, 1'b0);
						default: send_elem($urandom, 1'b0);
					endcase
				end
				if (rnd == 1)
					send_elem({hi[31:7], 7'd100}, 1'b1);
				else
					send_elem({hi[31:7], 7'd3}, 1'b1);
			end
		end
	endtask

	task automatic send_random_arrays(int n_items);
		value_t pool [12];
		int     psize;
		int     len;
		int     sent;
		int     r;
		int     i;
		sent = 0;
		while (sent < n_items) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				len = $urandom_range(1, 20);
			else if (r < 95)
				len = $urandom_range(21, 50);
			else
				len = $urandom_range(60, 80);
			psize = $urandom_range(1, 12);
			for (i = 0; i < psize; i++)
				pool[i] = $urandom;
			for (i = 0; i < len; i++) begin
				if ($urandom_range(0, 9) < 7)
					send_elem(pool[$urandom_range(0, psize - 1)], i == len - 1);
				else
					send_elem($urandom, i == len - 1);
			end
			sent += len;
		end
	endtask

	task automatic test_random_arrays();
		send_random_arrays(620);
	endtask

	task automatic test_backpressure();
		quiet    = 1'b1;
		hold_ask = 300;
		send_random_arrays(40);
		quiet    = 1'b0;
	endtask

	task automatic test_no_idle();
		quiet = 1'b1;
		send_random_arrays(150);
		quiet = 1'b0;
	endtask

	initial begin : run_tests
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_values();
		test_full_store();
		test_random_arrays();
		test_backpressure();
		test_no_idle();
		valid <= 1'b0;
		while (pending_res.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("tb_stable_duplicate_removal_top: clean");
		else
			$display("tb_stable_duplicate_removal_top: errors");
		$finish;
	end

endmodule
